@@ design/base64_stream_encoder_defines.svh @@
// Assertion helpers for the base64 stream encoder.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// Condition holds at every edge out of reset.
`define B64E_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("b64e assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define B64E_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64e assertion failed");

// Consequent holds in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64e assertion failed");

`endif

@@ design/b64e_pkg.sv @@
`default_nettype none
package b64e_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;
	localparam int unsigned MAX_CHARS = 4;

	localparam logic [6:0] PAD_CHAR = 7'h3D;

	localparam logic [2:0] RC_0 = 3'd0;
	localparam logic [2:0] RC_2 = 3'd2;
	localparam logic [2:0] RC_4 = 3'd4;

	typedef struct packed {
		logic [MAX_CHARS-1:0][6:0] chars;
		logic [2:0]                n;
		logic                      last;
	} job_t;

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		if (v < 6'd26) begin
			c = 7'h41 + {1'b0, v};
		end else if (v < 6'd52) begin
			c = 7'h61 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			c = 7'h30 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			c = 7'h2B;
		end else begin
			c = 7'h2F;
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ design/b64e_in_if.sv @@
`default_nettype none
interface b64e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;

	modport source(output valid, data_byte, byte_valid, end_of_message, input ready);
	modport sink(input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface
`default_nettype wire

@@ design/b64e_out_if.sv @@
`default_nettype none
interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       is_last;

	modport source(output valid, out_char, is_last, input ready);
	modport sink(input valid, out_char, is_last, output ready);
endinterface
`default_nettype wire

@@ design/b64e_front.sv @@
`default_nettype none
module b64e_front import b64e_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	b64e_in_if.sink   msg,
	output job_t      push_job,
	output logic      push_valid,
	input  wire logic push_ready
);

	logic [3:0] res_bits_q;
	logic [2:0] res_cnt_q;
	logic [3:0] bits_nx;
	logic [2:0] cnt_nx;
	logic [1:0] nb;
	logic [2:0] n;
	logic [MAX_CHARS-1:0][6:0] c;

	always_comb begin
		c       = '0;
		nb      = 2'd0;
		n       = 3'd0;
		bits_nx = res_bits_q;
		cnt_nx  = res_cnt_q;
		if (msg.byte_valid) begin
			case (res_cnt_q)
				RC_2: begin
					c[0]    = b64_char({res_bits_q[1:0], msg.data_byte[7:4]});
					nb      = 2'd1;
					bits_nx = msg.data_byte[3:0];
					cnt_nx  = RC_4;
				end
				RC_4: begin
					c[0]    = b64_char({res_bits_q, msg.data_byte[7:6]});
					c[1]    = b64_char(msg.data_byte[5:0]);
					nb      = 2'd2;
					bits_nx = 4'd0;
					cnt_nx  = RC_0;
				end
				default: begin
					c[0]    = b64_char(msg.data_byte[7:2]);
					nb      = 2'd1;
					bits_nx = {2'b00, msg.data_byte[1:0]};
					cnt_nx  = RC_2;
				end
			endcase
		end
		n = {1'b0, nb};
		if (msg.end_of_message) begin
			case (cnt_nx)
				RC_2: begin
					c[nb]         = b64_char({bits_nx[1:0], 4'b0000});
					c[nb + 2'd1]  = PAD_CHAR;
					c[nb + 2'd2]  = PAD_CHAR;
					n             = {1'b0, nb} + 3'd3;
				end
				RC_4: begin
					c[nb]         = b64_char({bits_nx, 2'b00});
					c[nb + 2'd1]  = PAD_CHAR;
					n             = {1'b0, nb} + 3'd2;
				end
				default: begin
					n = {1'b0, nb};
				end
			endcase
		end
	end

	assign push_job.chars = c;
	assign push_job.n     = n;
	assign push_job.last  = msg.end_of_message;
	assign push_valid     = msg.valid && (n != 3'd0);
	assign msg.ready      = push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bits_q <= 4'd0;
			res_cnt_q  <= RC_0;
		end else if (msg.valid && msg.ready) begin
			if (msg.end_of_message) begin
				res_bits_q <= 4'd0;
				res_cnt_q  <= RC_0;
			end else begin
				res_bits_q <= bits_nx;
				res_cnt_q  <= cnt_nx;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/b64e_queue.sv @@
`default_nettype none
module b64e_queue import b64e_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      push_job,
	input  wire logic push_valid,
	output logic      push_ready,
	output job_t      pop_job,
	output logic      pop_valid,
	input  wire logic pop_ready
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/b64e_back.sv @@
`default_nettype none
module b64e_back import b64e_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      head_job,
	input  wire logic head_valid,
	output logic      head_pop,
	b64e_out_if.source enc
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       is_last_q;
	logic       adv;
	logic       final_char;

	assign adv        = !out_valid_q || enc.ready;
	assign final_char = (({1'b0, idx_q} + 3'd1) == head_job.n);
	assign head_pop   = adv && head_valid && final_char;

	assign enc.valid    = out_valid_q;
	assign enc.out_char = out_char_q;
	assign enc.is_last  = is_last_q;

	always_ff @(posedge clk) begin
		if (adv && head_valid) begin
			out_char_q <= head_job.chars[idx_q];
			is_last_q  <= head_job.last && final_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= final_char ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/base64_stream_encoder.sv @@
// Base64 stream encoder, at most one byte in per item, one character out per item.
// The characters of an item are registered in the queue and then in the output register.
// Throughput: one character per cycle at the output register while enc.ready is high;
// a byte yields 1-2 characters and a closing item up to 4 on the single-character port.
// Reset: asynchronous, clears residue, queue and output valid; payload regs not reset.
`default_nettype none
`include "base64_stream_encoder_defines.svh"
module base64_stream_encoder import b64e_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	b64e_in_if.sink    msg,
	b64e_out_if.source enc
);

	job_t push_job;
	logic push_valid;
	logic push_ready;
	job_t head_job;
	logic head_valid;
	logic head_pop;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	b64e_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_job    (head_job),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop)
	);

	b64e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.enc        (enc)
	);

	`B64E_ASSERT_SAME(a_job_size, push_valid, (push_job.n != 3'd0) && (push_job.n <= 3'd4))
	`B64E_ASSERT_SAME(a_no_accept_full, !push_ready, !msg.ready)
	`B64E_ASSERT_NEXT(a_last_shown, head_pop && head_job.last, enc.valid && enc.is_last)

endmodule
`default_nettype wire
